// ===== rtl/prl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prl_pkg
// Shared types and constants for the priority ready list.
// ---------------------------------------------------------------------------
package prl_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W    = 8;

  localparam logic [SLOT_W-1:0] NIL = SLOT_W'(MAX_TASKS);

  typedef enum logic {
    OP_ACTIVATE  = 1'b0,
    OP_TERMINATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // ready list entry
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
  } rentry_t;

  // free list entry
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } fentry_t;

  // ready chain command
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
  } rcmd_t;

  // free chain command
  typedef struct packed {
    logic push;
    logic pop;
  } fcmd_t;

endpackage

// ===== rtl/prl_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prl_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface prl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [prl_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, op, priority_req, input ready);
  modport sink   (input valid, op, priority_req, output ready);
endinterface

interface prl_out_if;
  logic                        valid;
  logic                        ready;
  logic [prl_pkg::SLOT_W-1:0]  slot;
  logic [prl_pkg::SLOT_W-1:0]  running;
  logic                        preempted;
  logic [1:0]                  status;

  modport source (output valid, slot, running, preempted, status, input ready);
  modport sink   (input valid, slot, running, preempted, status, output ready);
endinterface

// ===== rtl/prl_ready_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prl_ready_cell
// One position of the sorted ready chain; shifts right on insert, left on pop.
// ---------------------------------------------------------------------------
module prl_ready_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  prl_pkg::rcmd_t   cmd,
  input  prl_pkg::rentry_t left_q,
  input  logic             left_keep,
  input  prl_pkg::rentry_t right_q,
  output prl_pkg::rentry_t ent_q,
  output logic             keep
);

  prl_pkg::rentry_t ent_r, ent_nxt;

  // entry stays put on insert: equal priority keeps arrival order
  assign keep  = ent_r.vld && (ent_r.prio >= cmd.prio);
  assign ent_q = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (!keep) begin
        if (left_keep) begin
          ent_nxt.vld  = 1'b1;
          ent_nxt.slot = cmd.slot;
          ent_nxt.prio = cmd.prio;
        end else begin
          ent_nxt = left_q;
        end
      end
    end else if (cmd.pop) begin
      ent_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.slot <= ent_nxt.slot;
    ent_r.prio <= ent_nxt.prio;
  end

endmodule

// ===== rtl/prl_free_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prl_free_cell
// One position of the free slot stack; shifts right on push, left on pop.
// ---------------------------------------------------------------------------
module prl_free_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [prl_pkg::SLOT_W-1:0] rst_slot,
  input  prl_pkg::fcmd_t             cmd,
  input  prl_pkg::fentry_t           left_q,
  input  prl_pkg::fentry_t           right_q,
  output prl_pkg::fentry_t           ent_q
);

  prl_pkg::fentry_t ent_r, ent_nxt;

  assign ent_q = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.push) begin
      ent_nxt = left_q;
    end else if (cmd.pop) begin
      ent_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld  <= 1'b1;
      ent_r.slot <= rst_slot;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== rtl/priority_ready_list.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_ready_list
// Task slot table: sorted ready chain of cells plus a free slot stack.
//
//   channel  dir  payload                              transfer when
//   in_ch    in   op, priority_req                     valid & ready
//   out_ch   out  slot, running, preempted, status     valid & ready
//
// Every ready cell compares its priority with the request in parallel, and the
// chain shifts in the same cycle that the request transfers.
// The result register must be empty or draining for a request to transfer.
// Reset (synchronous, active low) empties the ready chain and loads the free
// stack with slots 0 up to the last, slot 0 on top.
// ---------------------------------------------------------------------------
module priority_ready_list (
  input  logic      clk,
  input  logic      rst_n,
  prl_in_if.sink    in_ch,
  prl_out_if.source out_ch
);

  localparam int N = prl_pkg::MAX_TASKS;

  prl_pkg::rentry_t rd_q   [N];
  logic             rd_keep[N];
  prl_pkg::fentry_t fr_q   [N];
  prl_pkg::rcmd_t   rcmd;
  prl_pkg::fcmd_t   fcmd;

  logic                       acc;
  logic                       out_valid_r;
  logic [prl_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [prl_pkg::SLOT_W-1:0] running_r, running_nxt;
  logic                       preempted_r, preempted_nxt;
  prl_pkg::status_t           status_r, status_nxt;
  logic [prl_pkg::SLOT_W-1:0] old_head, second;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign old_head = rd_q[0].vld ? rd_q[0].slot : prl_pkg::NIL;
  assign second   = rd_q[1].vld ? rd_q[1].slot : prl_pkg::NIL;

  always_comb begin
    rcmd          = '0;
    fcmd          = '0;
    rcmd.prio     = in_ch.priority_req;
    rcmd.slot     = fr_q[0].slot;
    slot_nxt      = prl_pkg::NIL;
    running_nxt   = old_head;
    preempted_nxt = 1'b0;
    status_nxt    = prl_pkg::ST_OK;
    if (prl_pkg::op_t'(in_ch.op) == prl_pkg::OP_ACTIVATE) begin
      if (!fr_q[0].vld) begin
        status_nxt = prl_pkg::ST_FULL;
      end else begin
        rcmd.ins = acc;
        fcmd.pop = acc;
        slot_nxt = fr_q[0].slot;
        if (!rd_keep[0]) begin
          running_nxt   = fr_q[0].slot;
          preempted_nxt = 1'b1;
        end
      end
    end else begin
      if (!rd_q[0].vld) begin
        running_nxt = prl_pkg::NIL;
        status_nxt  = prl_pkg::ST_EMPTY;
      end else begin
        rcmd.pop      = acc;
        fcmd.push     = acc;
        slot_nxt      = rd_q[0].slot;
        running_nxt   = second;
        preempted_nxt = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    prl_pkg::rentry_t r_left, r_right;
    logic             r_left_keep;
    prl_pkg::fentry_t f_left, f_right;

    if (i == 0) begin : g_first
      assign r_left      = '0;
      assign r_left_keep = 1'b1;
      assign f_left      = {1'b1, rd_q[0].slot};
    end else begin : g_mid
      assign r_left      = rd_q[i-1];
      assign r_left_keep = rd_keep[i-1];
      assign f_left      = fr_q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_right = '0;
      assign f_right = '0;
    end else begin : g_inner
      assign r_right = rd_q[i+1];
      assign f_right = fr_q[i+1];
    end

    prl_ready_cell u_rcell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (rcmd),
      .left_q    (r_left),
      .left_keep (r_left_keep),
      .right_q   (r_right),
      .ent_q     (rd_q[i]),
      .keep      (rd_keep[i])
    );

    prl_free_cell u_fcell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rst_slot (prl_pkg::SLOT_W'(i)),
      .cmd      (fcmd),
      .left_q   (f_left),
      .right_q  (f_right),
      .ent_q    (fr_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (acc) begin
      slot_r      <= slot_nxt;
      running_r   <= running_nxt;
      preempted_r <= preempted_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.slot      = slot_r;
  assign out_ch.running   = running_r;
  assign out_ch.preempted = preempted_r;
  assign out_ch.status    = status_r;

endmodule
